// ----- hw/rtl/ffga_pkg.sv -----
`default_nettype none

package ffga_pkg;

    // Default grid limits
    localparam int MAX_COLS_DEF = 128;
    localparam int MAX_ROWS_DEF = 128;

    // Field widths
    localparam int KIND_W    = 2;
    localparam int POS_W     = 7;
    localparam int TIMER_W   = 9;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 3;

    // Item operations
    localparam logic [KIND_W-1:0] OP_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] OP_READ  = 2'd1;
    localparam logic [KIND_W-1:0] OP_STEP  = 2'd2;
    localparam logic [KIND_W-1:0] OP_NONE  = 2'd3;

    // Cell types
    localparam logic [KIND_W-1:0] CELL_NORMAL  = 2'd0;
    localparam logic [KIND_W-1:0] CELL_BURNING = 2'd1;
    localparam logic [KIND_W-1:0] CELL_REGROW  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COLS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BURN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REGROW = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REST   = 3'd4;

    // Configuration reset values
    localparam logic [CFG_W-1:0] COLS_RST   = 8'd100;
    localparam logic [CFG_W-1:0] ROWS_RST   = 8'd100;
    localparam logic [CFG_W-1:0] BURN_RST   = 8'd12;
    localparam logic [CFG_W-1:0] REGROW_RST = 8'd2;
    localparam logic [CFG_W-1:0] REST_RST   = 8'd8;

    // One stored cell: type in the upper bits, timer below
    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic signed [TIMER_W-1:0] timer;
    } t_cell;

    localparam int CELL_BITS = $bits(t_cell);

endpackage

`default_nettype wire

// ----- hw/rtl/ffga_item_if.sv -----
`default_nettype none

interface ffga_item_if import ffga_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [KIND_W-1:0]         kind;
    logic [POS_W-1:0]          col;
    logic [POS_W-1:0]          row;
    logic [KIND_W-1:0]         cell_kind;
    logic signed [TIMER_W-1:0] cell_timer;

    modport source (output valid, kind, col, row, cell_kind, cell_timer, input ready);
    modport sink   (input valid, kind, col, row, cell_kind, cell_timer, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/ffga_res_if.sv -----
`default_nettype none

interface ffga_res_if import ffga_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [KIND_W-1:0]         out_kind;
    logic signed [TIMER_W-1:0] out_timer;

    modport source (output valid, out_kind, out_timer, input ready);
    modport sink   (input valid, out_kind, out_timer, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/ffga_ram.sv -----
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data
module ffga_ram import ffga_pkg::*; #(
    parameter int WIDTH = CELL_BITS,
    parameter int DEPTH = MAX_COLS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/forest_fire_grid_automaton.sv -----
// Write and unused items: result registered at the accepting edge.
// Read items: the cell store read is registered, then the result is registered from it.
// Generation items: the sweep visits one cell per cycle through the single read port of
// the cell store, then a drain state registers the result.
// One item is in work at a time; the next is taken once the result register is free.
// Reset is synchronous: it restores the registers to their defaults and clears control
// state. The cell store is not cleared; cells are defined once written.
`default_nettype none

module forest_fire_grid_automaton import ffga_pkg::*; #(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata,
    ffga_item_if.sink                 i_item,
    ffga_res_if.source                o_res
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int BW    = $clog2(DEPTH + MAX_COLS + 1);
    localparam int CW    = $clog2(MAX_COLS + 1);
    localparam int CAW   = $clog2(MAX_COLS);
    localparam int RW    = $clog2(MAX_ROWS + 1);

    typedef enum logic [1:0] {S_IDLE, S_READ, S_STEP, S_DRAIN} t_state;

    t_state r_state;

    // Configuration registers
    logic [CFG_W-1:0] r_cols, r_rows, r_burn, r_regrow, r_rest;

    // Sweep issue counters
    logic [CW-1:0] r_iss_col;
    logic [RW-1:0] r_iss_row;
    logic [BW-1:0] r_iss_base;

    // Data-return stage of the sweep
    logic          r_s1_valid;
    logic [CW-1:0] r_s1_col;
    logic [RW-1:0] r_s1_row;
    logic [BW-1:0] r_s1_base;

    // 3x3 window: burning flags of two columns (above, current, below) and the center cell
    logic [2:0] r_wl_burn, r_wm_burn;
    t_cell      r_wm_cell;

    logic r_rd_inside;

    // Result register
    logic                      r_out_valid;
    logic [KIND_W-1:0]         r_out_kind;
    logic signed [TIMER_W-1:0] r_out_timer;
    logic                      out_load;
    logic                      n_out_valid;

    // Memory ports
    logic          st_we;
    logic [AW-1:0] st_waddr, st_raddr;
    t_cell         st_wdata, st_rdata;
    logic          lb_we;
    logic [CAW-1:0] lb_waddr, lb_raddr;
    t_cell         la_rdata, lb_rdata;

    logic [CW-1:0] nc;
    logic [RW-1:0] nr;
    logic          in_fire;
    logic          item_inside;
    logic [AW-1:0] item_addr;
    t_cell         item_cell;
    logic          col_ok, above_ok, cur_ok, below_ok;
    logic [2:0]    cur_burn;
    logic          center_act;
    logic [3:0]    burn_cnt;
    t_cell         new_cell;
    logic [BW-1:0] sw_full;
    logic [BW-1:0] sr_full;
    logic          sweep_we;

    // Cell rule for one generation
    function automatic t_cell next_cell(input t_cell c, input logic [3:0] cnt,
                                        input logic [CFG_W-1:0] burn,
                                        input logic [CFG_W-1:0] regrow,
                                        input logic [CFG_W-1:0] rest);
        t_cell n;
        n = c;
        if (c.timer > 9'sd0) begin
            if (c.kind == CELL_NORMAL) begin
                n.timer = c.timer - $signed({5'd0, cnt});
            end else begin
                n.timer = c.timer - 9'sd1;
            end
        end else if (c.kind == CELL_NORMAL) begin
            n.kind  = CELL_BURNING;
            n.timer = $signed({1'b0, burn});
        end else if (c.kind == CELL_BURNING) begin
            n.kind  = CELL_REGROW;
            n.timer = $signed({1'b0, regrow});
        end else begin
            n.kind  = CELL_NORMAL;
            n.timer = $signed({1'b0, rest});
        end
        return n;
    endfunction

    // Active grid size, saturated to the store
    always_comb begin
        nc = (int'(r_cols) > MAX_COLS) ? CW'(MAX_COLS) : CW'(r_cols);
        nr = (int'(r_rows) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(r_rows);
    end

    // Input handshake and item decode
    assign i_item.ready = (r_state == S_IDLE) && (!r_out_valid || o_res.ready);
    assign in_fire      = i_item.valid && i_item.ready;

    always_comb begin
        item_inside = (int'(i_item.col) < MAX_COLS) && (int'(i_item.row) < MAX_ROWS);
        item_addr   = AW'(int'(i_item.row) * MAX_COLS + int'(i_item.col));
        item_cell.kind  = (i_item.cell_kind == CELL_BURNING || i_item.cell_kind == CELL_REGROW)
                          ? i_item.cell_kind : CELL_NORMAL;
        item_cell.timer = i_item.cell_timer;
    end

    // Result register: loaded when an item finishes, emptied when taken
    always_comb begin
        out_load = (r_state == S_READ) || (r_state == S_DRAIN)
                || (in_fire && (i_item.kind != OP_READ)
                    && !(i_item.kind == OP_STEP && nc != '0 && nr != '0));
        n_out_valid = out_load || (r_out_valid && !o_res.ready);
    end

    // Return stage: mask neighbors outside the active grid
    always_comb begin
        col_ok   = r_s1_col < nc;
        above_ok = col_ok && (r_s1_row >= RW'(2));
        cur_ok   = col_ok && (r_s1_row != '0);
        below_ok = col_ok && (r_s1_row < nr);
        cur_burn = {above_ok && (la_rdata.kind == CELL_BURNING),
                    cur_ok   && (lb_rdata.kind == CELL_BURNING),
                    below_ok && (st_rdata.kind == CELL_BURNING)};
        center_act = r_s1_valid && (r_s1_col != '0) && (r_s1_row != '0);
        burn_cnt = 4'(r_wl_burn[0]) + 4'(r_wl_burn[1]) + 4'(r_wl_burn[2])
                 + 4'(r_wm_burn[0]) + 4'(r_wm_burn[2])
                 + 4'(cur_burn[0]) + 4'(cur_burn[1]) + 4'(cur_burn[2]);
        new_cell = next_cell(r_wm_cell, burn_cnt, r_burn, r_regrow, r_rest);
        // center is column col-1 of row row-1
        sw_full  = r_s1_base - BW'(MAX_COLS) + BW'(r_s1_col) - BW'(1);
        sr_full  = r_iss_base + BW'(r_iss_col);
        sweep_we = center_act;
    end

    // Cell store port selection
    always_comb begin
        st_we    = sweep_we || (in_fire && (i_item.kind == OP_WRITE) && item_inside);
        st_waddr = sweep_we ? AW'(sw_full) : item_addr;
        st_wdata = sweep_we ? new_cell : item_cell;
        st_raddr = (r_state == S_STEP) ? AW'(sr_full) : item_addr;
    end

    // Line buffers: above row takes the old current row, current row takes the row below
    always_comb begin
        lb_we    = r_s1_valid && col_ok;
        lb_waddr = CAW'(r_s1_col);
        lb_raddr = CAW'(r_iss_col);
    end

    ffga_ram #(.WIDTH(CELL_BITS), .DEPTH(DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    ffga_ram #(.WIDTH(CELL_BITS), .DEPTH(MAX_COLS)) u_row_above (
        .i_clk   (i_clk),
        .i_we    (lb_we),
        .i_waddr (lb_waddr),
        .i_wdata (lb_rdata),
        .i_raddr (lb_raddr),
        .o_rdata (la_rdata)
    );

    ffga_ram #(.WIDTH(CELL_BITS), .DEPTH(MAX_COLS)) u_row_cur (
        .i_clk   (i_clk),
        .i_we    (lb_we),
        .i_waddr (lb_waddr),
        .i_wdata (st_rdata),
        .i_raddr (lb_raddr),
        .o_rdata (lb_rdata)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols   <= COLS_RST;
            r_rows   <= ROWS_RST;
            r_burn   <= BURN_RST;
            r_regrow <= REGROW_RST;
            r_rest   <= REST_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_COLS:   r_cols   <= i_cfg_wdata;
                REG_ROWS:   r_rows   <= i_cfg_wdata;
                REG_BURN:   r_burn   <= i_cfg_wdata;
                REG_REGROW: r_regrow <= i_cfg_wdata;
                REG_REST:   r_rest   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Window shift
    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_wl_burn <= (r_s1_col == '0) ? 3'b000 : r_wm_burn;
            r_wm_burn <= cur_burn;
            r_wm_cell <= lb_rdata;
        end
    end

    // Control: state, sweep counters, result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_iss_col   <= '0;
            r_iss_row   <= '0;
            r_iss_base  <= '0;
            r_rd_inside <= 1'b0;
            r_out_kind  <= CELL_NORMAL;
            r_out_timer <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_s1_valid  <= (r_state == S_STEP);
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        unique case (i_item.kind)
                            OP_READ: begin
                                r_rd_inside <= item_inside;
                                r_state     <= S_READ;
                            end
                            OP_STEP: begin
                                r_iss_col  <= '0;
                                r_iss_row  <= '0;
                                r_iss_base <= '0;
                                if (nc == '0 || nr == '0) begin
                                    r_out_kind  <= CELL_NORMAL;
                                    r_out_timer <= '0;
                                end else begin
                                    r_state <= S_STEP;
                                end
                            end
                            OP_WRITE, OP_NONE: begin
                                r_out_kind  <= CELL_NORMAL;
                                r_out_timer <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_READ: begin
                    r_out_kind  <= r_rd_inside ? st_rdata.kind : CELL_NORMAL;
                    r_out_timer <= r_rd_inside ? st_rdata.timer : '0;
                    r_state     <= S_IDLE;
                end
                S_STEP: begin
                    r_s1_col   <= r_iss_col;
                    r_s1_row   <= r_iss_row;
                    r_s1_base  <= r_iss_base;
                    if (r_iss_col == nc) begin
                        r_iss_col  <= '0;
                        r_iss_row  <= r_iss_row + RW'(1);
                        r_iss_base <= r_iss_base + BW'(MAX_COLS);
                        if (r_iss_row == nr) begin
                            r_state <= S_DRAIN;
                        end
                    end else begin
                        r_iss_col <= r_iss_col + CW'(1);
                    end
                end
                S_DRAIN: begin
                    r_out_kind  <= CELL_NORMAL;
                    r_out_timer <= '0;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.out_kind  = r_out_kind;
    assign o_res.out_timer = r_out_timer;

    // The sweep never writes the cell it is reading in the same cycle
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (sweep_we && r_state == S_STEP) |-> (st_waddr != st_raddr))
        else $error("sweep write and read hit the same cell");

    // The result register is empty whenever an item is in work
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !r_out_valid)
        else $error("result pending while an item is in work");

    // Generation writes happen only during a sweep
    a_sweep_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sweep_we |-> (r_state == S_STEP || r_state == S_DRAIN))
        else $error("cell update outside a sweep");

endmodule

`default_nettype wire
